FILE: design/satlb_pkg.sv
// Shared types and constants of the set-associative TLB.
// No dependencies; used by satlb_ctrl, satlb_dp and the top level.
package satlb_pkg;

    localparam int OP_W      = 3;
    localparam int VADDR_W   = 32;
    localparam int SETSEL_W  = 6;
    localparam int WAYSEL_W  = 2;
    localparam int TAG_W     = 32;
    localparam int PPN_W     = 32;
    localparam int OFF_W     = 31;
    localparam int OB_W      = 5;
    localparam int SB_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 104;
    localparam int SETRAW_W  = 7;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_LOOKUP  = 3'd0;
    localparam t_op OP_FIND    = 3'd1;
    localparam t_op OP_ALLOC   = 3'd2;
    localparam t_op OP_FILL    = 3'd3;
    localparam t_op OP_INVAL   = 3'd4;
    localparam t_op OP_SETPEND = 3'd5;

    localparam t_cfg_idx CFG_OFFSET_BITS = 2'd0;
    localparam t_cfg_idx CFG_SET_BITS    = 2'd1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: design/satlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module satlb_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [(D>1?$clog2(D):1)-1:0] i_waddr,
    input  logic [W-1:0]                 i_wdata,
    input  logic [(D>1?$clog2(D):1)-1:0] i_raddr,
    output logic [W-1:0]                 o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/satlb_ctrl.sv
// Controller: sequences accept (row read) and execute (compare, write back).
// Depends on satlb_pkg.
module satlb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  satlb_pkg::t_sts i_sts,
    output satlb_pkg::t_cmd o_cmd
);
    satlb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= satlb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            satlb_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = satlb_pkg::ST_EXEC;
                end
            end
            satlb_pkg::ST_EXEC: begin
                // hold until the output register can take the result
                o_cmd.exec = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = satlb_pkg::ST_IDLE;
                end
            end
            default: n_state = satlb_pkg::ST_IDLE;
        endcase
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == satlb_pkg::ST_EXEC)
        else $error("accept not followed by execute");
    a_exec_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_state == satlb_pkg::ST_IDLE)
        else $error("execute not followed by idle");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == satlb_pkg::ST_EXEC && !i_sts.out_free) |=> r_state == satlb_pkg::ST_EXEC)
        else $error("stalled execute lost");
endmodule

FILE: design/satlb_dp.sv
// Datapath: config registers, address split, set storage, compare and LRU update.
// Depends on satlb_pkg and satlb_ram.
module satlb_dp #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  satlb_pkg::t_cmd                     i_cmd,
    output satlb_pkg::t_sts                     o_sts,
    input  logic [satlb_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic [satlb_pkg::OP_W-1:0]          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [satlb_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [satlb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [satlb_pkg::OB_W-1:0]          i_cfg_data
);
    localparam int SI_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WI_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W = satlb_pkg::TAG_W;
    localparam int PPN_W = satlb_pkg::PPN_W;
    localparam int MODN  = 1 << satlb_pkg::SETRAW_W;

    // config
    logic [satlb_pkg::OB_W-1:0] r_ob;
    logic [satlb_pkg::SB_W-1:0] r_sb;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob <= satlb_pkg::OB_W'(12);
            r_sb <= satlb_pkg::SB_W'(6);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == satlb_pkg::CFG_OFFSET_BITS) begin
                r_ob <= i_cfg_data;
            end else if (i_cfg_index == satlb_pkg::CFG_SET_BITS) begin
                r_sb <= i_cfg_data[satlb_pkg::SB_W-1:0];
            end
        end
    end

    // input fields
    satlb_pkg::t_op   w_op;
    logic [31:0]      w_vaddr;
    logic [5:0]       w_set_sel;
    logic [1:0]       w_way_sel;
    logic [31:0]      w_tag_value;
    logic [31:0]      w_ppn_value;
    logic             w_pend_value;

    assign w_op         = i_s_tuser;
    assign w_vaddr      = i_s_tdata[31:0];
    assign w_set_sel    = i_s_tdata[37:32];
    assign w_way_sel    = i_s_tdata[39:38];
    assign w_tag_value  = i_s_tdata[71:40];
    assign w_ppn_value  = i_s_tdata[103:72];
    assign w_pend_value = i_s_tdata[104];

    // set index modulo SETS, as a constant table
    logic [SI_W-1:0] w_mod_tab [MODN];
    for (genvar g = 0; g < MODN; g++) begin : g_mod
        assign w_mod_tab[g] = SI_W'(g % SETS);
    end

    // address split
    logic [32:0]                   w_off_mask;
    logic [31:0]                   w_shift;
    logic [7:0]                    w_set_mask;
    logic [satlb_pkg::SETRAW_W-1:0] w_set_raw;
    logic [5:0]                    w_total;
    logic [31:0]                   w_tag;
    logic [satlb_pkg::OFF_W-1:0]   w_off;
    logic                          w_addr_op;
    logic [SI_W-1:0]               w_row;

    always_comb begin
        w_off_mask = (33'd1 << r_ob) - 33'd1;
        w_off      = w_vaddr[30:0] & w_off_mask[30:0];
        w_shift    = w_vaddr >> r_ob;
        w_set_mask = (8'd1 << r_sb) - 8'd1;
        w_set_raw  = w_shift[satlb_pkg::SETRAW_W-1:0] & w_set_mask[satlb_pkg::SETRAW_W-1:0];
        w_total    = {1'b0, r_ob} + {3'b000, r_sb};
        w_tag      = (w_total >= 6'd32) ? 32'd0 : (w_vaddr >> w_total);
        w_addr_op  = (w_op == satlb_pkg::OP_LOOKUP) || (w_op == satlb_pkg::OP_FIND);
        w_row      = w_addr_op ? w_mod_tab[w_set_raw] : w_mod_tab[{1'b0, w_set_sel}];
    end

    // captured operation
    satlb_pkg::t_op               r_op;
    logic [SI_W-1:0]              r_row;
    logic [satlb_pkg::OFF_W-1:0]  r_off;
    logic [31:0]                  r_atag;
    logic [1:0]                   r_way;
    logic [31:0]                  r_tagv;
    logic [31:0]                  r_ppnv;
    logic                         r_pendv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= w_op;
            r_row   <= w_row;
            r_off   <= w_off;
            r_atag  <= w_tag;
            r_way   <= w_way_sel;
            r_tagv  <= w_tag_value;
            r_ppnv  <= w_ppn_value;
            r_pendv <= w_pend_value;
        end
    end

    // storage; a set whose row mark is clear reads as invalid, not pending,
    // and in reset LRU order
    logic [SETS-1:0] r_row_ok;

    logic [SI_W-1:0]            w_raddr;
    logic [WAYS*TAG_W-1:0]      w_vtag_row, w_ptag_row, n_vtag_row, n_ptag_row;
    logic [WAYS*PPN_W-1:0]      w_ppn_row, n_ppn_row;
    logic [WAYS*WI_W-1:0]       w_lru_raw, w_lru_row, n_lru_row;
    logic [2*WAYS-1:0]          w_flag_raw, n_flag_row;
    logic                       w_we_vtag, w_we_ppn, w_we_ptag, w_we_row;

    assign w_raddr = i_cmd.accept ? w_row : r_row;

    satlb_ram #(.W(WAYS*TAG_W), .D(SETS)) u_vtag (
        .i_clk(i_clk), .i_we(w_we_vtag), .i_waddr(r_row), .i_wdata(n_vtag_row),
        .i_raddr(w_raddr), .o_rdata(w_vtag_row));
    satlb_ram #(.W(WAYS*PPN_W), .D(SETS)) u_ppn (
        .i_clk(i_clk), .i_we(w_we_ppn), .i_waddr(r_row), .i_wdata(n_ppn_row),
        .i_raddr(w_raddr), .o_rdata(w_ppn_row));
    satlb_ram #(.W(WAYS*TAG_W), .D(SETS)) u_ptag (
        .i_clk(i_clk), .i_we(w_we_ptag), .i_waddr(r_row), .i_wdata(n_ptag_row),
        .i_raddr(w_raddr), .o_rdata(w_ptag_row));
    satlb_ram #(.W(WAYS*WI_W), .D(SETS)) u_lru (
        .i_clk(i_clk), .i_we(w_we_row), .i_waddr(r_row), .i_wdata(n_lru_row),
        .i_raddr(w_raddr), .o_rdata(w_lru_raw));
    // pending flags in the upper half, valid flags in the lower half
    satlb_ram #(.W(2*WAYS), .D(SETS)) u_flag (
        .i_clk(i_clk), .i_we(w_we_row), .i_waddr(r_row), .i_wdata(n_flag_row),
        .i_raddr(w_raddr), .o_rdata(w_flag_raw));

    // execute: compare, pick, build write-back rows
    logic [WAYS-1:0] w_vrow, w_prow, n_vrow, n_prow;
    logic            w_found;
    logic [WI_W-1:0] w_sel;
    logic            w_afound;
    logic [WI_W-1:0] w_victim, w_arank;
    logic            w_way_ok;
    logic [WI_W-1:0] w_wi;
    logic [PPN_W-1:0] w_hit_ppn;
    logic            w_match;

    always_comb begin
        w_vrow     = r_row_ok[r_row] ? w_flag_raw[WAYS-1:0] : '0;
        w_prow     = r_row_ok[r_row] ? w_flag_raw[2*WAYS-1:WAYS] : '0;
        w_way_ok   = 32'(r_way) < WAYS;
        w_wi       = WI_W'(32'(r_way));
        // unwritten LRU rows read as the reset order
        for (int w = 0; w < WAYS; w++) begin
            w_lru_row[w*WI_W +: WI_W] = r_row_ok[r_row] ? w_lru_raw[w*WI_W +: WI_W] : WI_W'(w);
        end

        // lowest matching way
        w_found = 1'b0;
        w_sel   = '0;
        for (int w = WAYS-1; w >= 0; w--) begin
            if (r_op == satlb_pkg::OP_LOOKUP) begin
                w_match = w_vrow[w] && (w_vtag_row[w*TAG_W +: TAG_W] == r_atag);
            end else begin
                w_match = w_prow[w] && (w_ptag_row[w*TAG_W +: TAG_W] == r_atag);
            end
            if (w_match) begin
                w_found = 1'b1;
                w_sel   = WI_W'(w);
            end
        end
        w_hit_ppn = w_ppn_row[w_sel*PPN_W +: PPN_W];

        // victim: non-pending way nearest the LRU end
        w_afound = 1'b0;
        w_victim = '0;
        w_arank  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!w_prow[w] && (!w_afound || w_lru_row[w*WI_W +: WI_W] > w_arank)) begin
                w_afound = 1'b1;
                w_victim = WI_W'(w);
                w_arank  = w_lru_row[w*WI_W +: WI_W];
            end
        end

        n_vrow     = w_vrow;
        n_prow     = w_prow;
        n_vtag_row = w_vtag_row;
        n_ppn_row  = w_ppn_row;
        n_ptag_row = w_ptag_row;
        n_lru_row  = w_lru_row;
        w_we_vtag  = 1'b0;
        w_we_ppn   = 1'b0;
        w_we_ptag  = 1'b0;

        priority case (r_op)
            satlb_pkg::OP_ALLOC: begin
                if (w_afound) begin
                    n_prow[w_victim] = 1'b1;
                    n_ptag_row[w_victim*TAG_W +: TAG_W] = r_tagv;
                    for (int w = 0; w < WAYS; w++) begin
                        if (WI_W'(w) == w_victim) begin
                            n_lru_row[w*WI_W +: WI_W] = '0;
                        end else if (w_lru_row[w*WI_W +: WI_W] < w_arank) begin
                            n_lru_row[w*WI_W +: WI_W] = w_lru_row[w*WI_W +: WI_W] + 1'b1;
                        end
                    end
                    w_we_ptag = i_cmd.exec;
                end
            end
            satlb_pkg::OP_FILL: begin
                if (w_way_ok) begin
                    n_prow[w_wi] = 1'b0;
                    n_vrow[w_wi] = 1'b1;
                    n_vtag_row[w_wi*TAG_W +: TAG_W] = r_tagv;
                    n_ppn_row[w_wi*PPN_W +: PPN_W]  = r_ppnv;
                    w_we_vtag = i_cmd.exec;
                    w_we_ppn  = i_cmd.exec;
                end
            end
            satlb_pkg::OP_INVAL: begin
                if (w_way_ok) begin
                    n_vrow[w_wi] = 1'b0;
                end
            end
            satlb_pkg::OP_SETPEND: begin
                if (w_way_ok) begin
                    n_prow[w_wi] = r_pendv;
                    n_ptag_row[w_wi*TAG_W +: TAG_W] = r_tagv;
                    w_we_ptag = i_cmd.exec;
                end
            end
            default: begin
            end
        endcase

        // write flags and LRU of the set back together on every write op
        n_flag_row = {n_prow, n_vrow};
        w_we_row   = i_cmd.exec && ((r_op == satlb_pkg::OP_ALLOC) ||
                                    (r_op == satlb_pkg::OP_FILL) ||
                                    (r_op == satlb_pkg::OP_INVAL) ||
                                    (r_op == satlb_pkg::OP_SETPEND));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (w_we_row) begin
            r_row_ok[r_row] <= 1'b1;
        end
    end

    // output register
    logic                                r_ov;
    logic [satlb_pkg::OUT_DATA_W-1:0]    r_odata;
    logic [satlb_pkg::OUT_DATA_W-1:0]    n_odata;
    logic                                w_aop;

    always_comb begin
        w_aop   = (r_op == satlb_pkg::OP_LOOKUP) || (r_op == satlb_pkg::OP_FIND);
        n_odata = '0;
        if (w_aop) begin
            n_odata[0]      = w_found;
            n_odata[2:1]    = w_found ? 2'(32'(w_sel)) : 2'd0;
            n_odata[34:3]   = (w_found && r_op == satlb_pkg::OP_LOOKUP) ? w_hit_ppn : 32'd0;
            n_odata[65:35]  = r_off;
            n_odata[71:66]  = 6'(32'(r_row));
            n_odata[103:72] = r_atag;
        end else if (r_op == satlb_pkg::OP_ALLOC) begin
            n_odata[0]   = w_afound;
            n_odata[2:1] = w_afound ? 2'(32'(w_victim)) : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.exec) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_odata <= n_odata;
        end
    end

    assign o_sts.out_free = !r_ov || i_m_tready;
    assign o_m_tvalid     = r_ov;
    assign o_m_tdata      = r_odata;
endmodule

FILE: design/set_assoc_tlb_lru_pending_core.sv
// Top level of the set-associative TLB with LRU order and pending marks.
// Depends on satlb_pkg, satlb_ctrl, satlb_dp (and through it satlb_ram).
//
//  channel  | direction | signals                                  | word
//  ---------+-----------+------------------------------------------+-------------------------
//  s (in)   | slave     | i_s_tvalid o_s_tready i_s_tdata i_s_tuser | one TLB operation
//  m (out)  | master    | o_m_tvalid i_m_tready o_m_tdata           | one result
//  cfg      | slave     | i_cfg_valid o_cfg_ready i_cfg_index/data  | one register write
//
// Each word passes through accept, which reads the set row from the flag, tag,
// page, pending-tag and LRU RAMs, and execute, which compares all ways and writes back.
// The execute cycle holds while the output register is full and not taken.
// Reset clears the per-set row marks at once, idles the controller, empties the output
// register and loads 12 offset and 6 set bits; a set whose mark is clear reads as
// invalid, not pending and in reset LRU order. Config writes are taken in any cycle.
module set_assoc_tlb_lru_pending_core #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // op[2:0]
    input  logic [satlb_pkg::OP_W-1:0]        i_s_tuser,
    // vaddr[31:0] set_sel[37:32] way_sel[39:38] tag_value[71:40]
    // ppn_value[103:72] pending_value[104] zero[111:105]
    input  logic [satlb_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // found[0] way_out[2:1] ppn_out[34:3] page_offset[65:35]
    // set_out[71:66] tag_out[103:72]
    output logic [satlb_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [satlb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [satlb_pkg::OB_W-1:0]        i_cfg_data
);
    satlb_pkg::t_cmd w_cmd;
    satlb_pkg::t_sts w_sts;

    // sequence accept and execute
    satlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // storage, compare and result register
    satlb_dp #(.WAYS(WAYS), .SETS(SETS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );
endmodule
